FILE: rtl/round_robin_task_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin task scheduler
// Immediate-consequence and next-cycle property forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrts: same-cycle property failed");

// Consequence must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrts: next-cycle property failed");

`endif

FILE: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int CFG_W     = 16;
   localparam int TASK_ID_W = 4;
   localparam int FIELD_W   = 16;

   localparam logic [CFG_W-1:0] MAIN_SLICE_RESET = 16'd10;

   typedef enum logic [2:0] {
      CMD_INIT    = 3'd0,
      CMD_TICK    = 3'd1,
      CMD_CREATE  = 3'd2,
      CMD_SUSPEND = 3'd3,
      CMD_RESUME  = 3'd4,
      CMD_SLEEP   = 3'd5,
      CMD_FINISH  = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_SUSPENDED = 2'd0,
      ST_RUNNABLE  = 2'd1,
      ST_SLEEPING  = 2'd2,
      ST_FINISHED  = 2'd3
   } task_state_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [TASK_ID_W-1:0]   task_id;
      logic [FIELD_W-1:0]     tick_value;
   } req_type;

   typedef struct packed {
      logic                   switch_req;
      logic [TASK_ID_W-1:0]   next_task;
      logic [TASK_ID_W-1:0]   new_id;
      logic                   error;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } ram_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TK_RD,
      S_TK_UPD,
      S_SL_RD,
      S_SL_UPD,
      S_CUR_UPD,
      S_PK_START,
      S_PK_RD,
      S_PK_CHK,
      S_RL_RD,
      S_RL_WR,
      S_DONE
   } sched_state_type;

endpackage

FILE: rtl/rrts_dec_unit.sv
// ----------------------------------------------------------------------------
// rrts_dec_unit
// Shared saturating decrement with a zero test on the result.
// ----------------------------------------------------------------------------
module rrts_dec_unit
   import rrts_pkg::*;
#(
   parameter int WIDTH = 16
)
(
   input  logic [WIDTH-1:0] operand,
   output logic [WIDTH-1:0] result,
   output logic             is_zero
);

   // A count already at zero stays at zero.
   assign result  = (operand == '0) ? operand : operand - WIDTH'(1);
   assign is_zero = (result == '0);

endmodule

FILE: rtl/rrts_task_ram.sv
// ----------------------------------------------------------------------------
// rrts_task_ram
// Task table memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module rrts_task_ram
   import rrts_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int TICK_WIDTH = 16,
   parameter int ADDR_W     = $clog2(DEPTH)
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ram_ctl_type           ctl,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  task_state_type        wr_state,
   input  logic [TICK_WIDTH-1:0] wr_len,
   input  logic [TICK_WIDTH-1:0] wr_left,
   input  logic [TICK_WIDTH-1:0] wr_sleep,
   output task_state_type        rd_state,
   output logic [TICK_WIDTH-1:0] rd_len,
   output logic [TICK_WIDTH-1:0] rd_left,
   output logic [TICK_WIDTH-1:0] rd_sleep
);

   localparam int ROW_W = 2 + 3 * TICK_WIDTH;

   logic [ROW_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [ROW_W-1:0] rd_row_ff;
   logic             rd_valid_ff;
   logic             rd_first_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= {wr_state, wr_len, wr_left, wr_sleep};
      end
      if (ctl.rd_en) begin
         rd_row_ff   <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_first_ff <= (rd_addr == '0);
      end
   end

   // An entry that was never written since reset or init reads as its
   // reset value: task zero runnable, every other task suspended, counts zero.
   // A clear that comes with a write keeps only the row being written.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear) begin
         valid_ff <= ctl.wr_en ? (DEPTH'(1) << wr_addr) : '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_state = rd_valid_ff ? task_state_type'(rd_row_ff[ROW_W-1 -: 2])
                   : (rd_first_ff ? ST_RUNNABLE : ST_SUSPENDED);
   assign rd_len   = rd_valid_ff ? rd_row_ff[3*TICK_WIDTH-1 -: TICK_WIDTH] : '0;
   assign rd_left  = rd_valid_ff ? rd_row_ff[2*TICK_WIDTH-1 -: TICK_WIDTH] : '0;
   assign rd_sleep = rd_valid_ff ? rd_row_ff[TICK_WIDTH-1:0] : '0;

endmodule

FILE: rtl/round_robin_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin time-slice task scheduler with a table walked by a sequencer.
// ----------------------------------------------------------------------------
// The scheduler takes one command item at a time (init, tick, create,
// suspend, resume, sleep, finish) and returns one result item for it, giving
// the switch request, the task that runs afterwards, the id of a created task
// and an error flag. Every task row lives in a single-port-read,
// single-port-write memory, so the sequencer spends a read step and an act
// step on each row it visits. Init, create, unused commands and a suspend or
// resume with a bad task id go from decode straight to done; suspend and
// resume read the named row and then write its new state. Sleep and finish
// update the running row, then search round-robin for the next runnable
// task and reload its slice, keeping the running task when none is found.
// A tick walks every task in the table, counting sleepers down, then counts
// the running slice down and runs the same search when the slice expires.
// The block goes back to idle before the next item can be accepted.
// Reset and init clear the table at once through per-row valid bits, so no
// clearing pass is needed. The block is not ready while a command is in
// progress; a finished result sits in an output register until taken, and the
// next item is accepted meanwhile. The slice register written through the csr
// port takes effect at the next init.
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_unit_assert.svh"

module round_robin_task_scheduler_unit
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS  = 16,
   parameter int TICK_WIDTH = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // Sequencer and command registers.
   sched_state_type       state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [TASK_ID_W-1:0]  id_ff, id_in;
   logic [TICK_WIDTH-1:0] tv_ff, tv_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [IDX_W-1:0]      running_ff, running_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  sw_ff, sw_in;
   logic [TASK_ID_W-1:0]  nid_ff, nid_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [CFG_W-1:0]      main_slice_ff;

   // Task table port signals.
   ram_ctl_type           ram_ctl;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [IDX_W-1:0]      ram_wr_addr;
   task_state_type        wr_state;
   logic [TICK_WIDTH-1:0] wr_len;
   logic [TICK_WIDTH-1:0] wr_left;
   logic [TICK_WIDTH-1:0] wr_sleep;
   task_state_type        rd_state;
   logic [TICK_WIDTH-1:0] rd_len;
   logic [TICK_WIDTH-1:0] rd_left;
   logic [TICK_WIDTH-1:0] rd_sleep;

   // Shared decrement unit.
   logic [TICK_WIDTH-1:0] dec_operand;
   logic [TICK_WIDTH-1:0] dec_result;
   logic                  dec_zero;

   // Decode flags.
   logic                  table_full;
   logic                  bad_id;
   logic [CNT_W-1:0]      count_m1;
   logic                  tick_last;
   logic                  search_last;
   logic                  single_task;
   logic                  found;
   logic                  slot_free;
   logic                  rsp_load;
   logic [TICK_WIDTH-1:0] sleep_amt;
   logic [IDX_W-1:0]      idx_next;
   logic [IDX_W-1:0]      run_next;

   // Index that follows cur when the table holds n tasks.
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] cur,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(cur) + CNT_W'(1);
      return (inc == n) ? '0 : inc[IDX_W-1:0];
   endfunction

   rrts_task_ram #(
      .DEPTH      (MAX_TASKS),
      .TICK_WIDTH (TICK_WIDTH),
      .ADDR_W     (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ram_ctl),
      .rd_addr  (ram_rd_addr),
      .wr_addr  (ram_wr_addr),
      .wr_state (wr_state),
      .wr_len   (wr_len),
      .wr_left  (wr_left),
      .wr_sleep (wr_sleep),
      .rd_state (rd_state),
      .rd_len   (rd_len),
      .rd_left  (rd_left),
      .rd_sleep (rd_sleep)
   );

   // The one arithmetic unit counts sleepers down during the table walk and
   // the running slice down afterwards.
   assign dec_operand = (state_ff == S_TK_UPD) ? rd_sleep : rd_left;

   rrts_dec_unit #(
      .WIDTH (TICK_WIDTH)
   ) u_dec (
      .operand (dec_operand),
      .result  (dec_result),
      .is_zero (dec_zero)
   );

   assign table_full  = 32'(count_ff) >= MAX_TASKS;
   assign bad_id      = 32'(id_ff) >= MAX_TASKS;
   assign count_m1    = count_ff - CNT_W'(1);
   assign tick_last   = CNT_W'(idx_ff) == count_m1;
   assign search_last = CNT_W'(k_ff) == count_m1;
   assign single_task = count_ff == CNT_W'(1);
   assign found       = rd_state == ST_RUNNABLE;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load    = (state_ff == S_DONE) && slot_free;
   // A sleep of zero ticks lasts one tick.
   assign sleep_amt   = (tv_ff == '0) ? TICK_WIDTH'(1) : tv_ff;
   assign idx_next    = next_index(idx_ff, count_ff);
   assign run_next    = next_index(running_ff, count_ff);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (cmd_ff)
               CMD_TICK: begin
                  state_in = S_TK_RD;
               end
               CMD_SUSPEND, CMD_RESUME: begin
                  state_in = bad_id ? S_DONE : S_CUR_UPD;
               end
               CMD_SLEEP, CMD_FINISH: begin
                  state_in = S_CUR_UPD;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_TK_RD: begin
            state_in = S_TK_UPD;
         end
         S_TK_UPD: begin
            state_in = tick_last ? S_SL_RD : S_TK_RD;
         end
         S_SL_RD: begin
            state_in = S_SL_UPD;
         end
         S_SL_UPD: begin
            state_in = dec_zero ? S_PK_START : S_DONE;
         end
         S_CUR_UPD: begin
            if (cmd_ff == CMD_SLEEP || cmd_ff == CMD_FINISH) begin
               state_in = S_PK_START;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PK_START: begin
            state_in = single_task ? S_RL_RD : S_PK_RD;
         end
         S_PK_RD: begin
            state_in = S_PK_CHK;
         end
         S_PK_CHK: begin
            if (found) begin
               state_in = S_RL_WR;
            end else if (search_last) begin
               state_in = S_RL_RD;
            end else begin
               state_in = S_PK_RD;
            end
         end
         S_RL_RD: begin
            state_in = S_RL_WR;
         end
         S_RL_WR: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and table control for each sequencer step.
   always_comb begin
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      tv_in        = tv_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      running_in   = running_ff;
      count_in     = count_ff;
      sw_in        = sw_ff;
      nid_in       = nid_ff;
      err_in       = err_ff;
      ram_ctl      = '0;
      ram_rd_addr  = idx_ff;
      ram_wr_addr  = idx_ff;
      // Writes default to the row just read, so a step changes only its field.
      wr_state     = rd_state;
      wr_len       = rd_len;
      wr_left      = rd_left;
      wr_sleep     = rd_sleep;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload.cmd;
               id_in  = req_payload.task_id;
               tv_in  = TICK_WIDTH'(req_payload.tick_value);
               sw_in  = 1'b0;
               nid_in = '0;
               err_in = 1'b0;
            end
         end
         S_DECODE: begin
            case (cmd_ff)
               CMD_INIT: begin
                  ram_ctl.clear = 1'b1;
                  ram_ctl.wr_en = 1'b1;
                  ram_wr_addr   = '0;
                  wr_state      = ST_RUNNABLE;
                  wr_len        = TICK_WIDTH'(main_slice_ff);
                  wr_left       = TICK_WIDTH'(main_slice_ff);
                  wr_sleep      = '0;
                  count_in      = CNT_W'(1);
                  running_in    = '0;
               end
               CMD_TICK: begin
                  idx_in = '0;
               end
               CMD_CREATE: begin
                  if (table_full) begin
                     err_in = 1'b1;
                  end else begin
                     ram_ctl.wr_en = 1'b1;
                     ram_wr_addr   = IDX_W'(count_ff);
                     wr_state      = ST_RUNNABLE;
                     wr_len        = tv_ff;
                     wr_left       = '0;
                     wr_sleep      = '0;
                     nid_in        = TASK_ID_W'(count_ff);
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               CMD_SUSPEND, CMD_RESUME: begin
                  if (bad_id) begin
                     err_in = 1'b1;
                  end else begin
                     ram_ctl.rd_en = 1'b1;
                     ram_rd_addr   = IDX_W'(id_ff);
                     idx_in        = IDX_W'(id_ff);
                  end
               end
               CMD_SLEEP, CMD_FINISH: begin
                  ram_ctl.rd_en = 1'b1;
                  ram_rd_addr   = running_ff;
                  idx_in        = running_ff;
               end
               default: begin
               end
            endcase
         end
         S_TK_RD: begin
            ram_ctl.rd_en = 1'b1;
         end
         S_TK_UPD: begin
            // Sleepers count down and wake when their count reaches zero.
            if (rd_state == ST_SLEEPING) begin
               ram_ctl.wr_en = 1'b1;
               wr_sleep      = dec_result;
               if (dec_zero) begin
                  wr_state = ST_RUNNABLE;
               end
            end
            if (!tick_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SL_RD: begin
            ram_ctl.rd_en = 1'b1;
            ram_rd_addr   = running_ff;
         end
         S_SL_UPD: begin
            ram_ctl.wr_en = 1'b1;
            ram_wr_addr   = running_ff;
            wr_left       = dec_result;
            if (dec_zero) begin
               sw_in = 1'b1;
            end
         end
         S_CUR_UPD: begin
            ram_ctl.wr_en = 1'b1;
            case (cmd_ff)
               CMD_SUSPEND: begin
                  wr_state = ST_SUSPENDED;
               end
               CMD_RESUME: begin
                  wr_state = ST_RUNNABLE;
               end
               CMD_SLEEP: begin
                  wr_state = ST_SLEEPING;
                  wr_sleep = sleep_amt;
                  wr_left  = TICK_WIDTH'(1);
                  sw_in    = 1'b1;
               end
               default: begin
                  wr_state = ST_FINISHED;
                  sw_in    = 1'b1;
               end
            endcase
         end
         S_PK_START: begin
            if (single_task) begin
               idx_in = running_ff;
            end else begin
               idx_in = run_next;
               k_in   = IDX_W'(1);
            end
         end
         S_PK_RD: begin
            ram_ctl.rd_en = 1'b1;
         end
         S_PK_CHK: begin
            // With no other runnable task the running one keeps the processor.
            if (!found) begin
               if (search_last) begin
                  idx_in = running_ff;
               end else begin
                  idx_in = idx_next;
                  k_in   = k_ff + IDX_W'(1);
               end
            end
         end
         S_RL_RD: begin
            ram_ctl.rd_en = 1'b1;
         end
         S_RL_WR: begin
            ram_ctl.wr_en = 1'b1;
            wr_left       = rd_len;
            running_in    = idx_ff;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.switch_req = sw_ff;
               rsp_in.next_task  = TASK_ID_W'(running_ff);
               rsp_in.new_id     = nid_ff;
               rsp_in.error      = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= '0;
         count_ff      <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         main_slice_ff <= MAIN_SLICE_RESET;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            main_slice_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      id_ff  <= id_in;
      tv_ff  <= tv_in;
      idx_ff <= idx_in;
      k_ff   <= k_in;
      sw_ff  <= sw_in;
      nid_ff <= nid_in;
      err_ff <= err_in;
      rsp_ff <= rsp_in;
   end

   `RRTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `RRTS_ASSERT_IMPL(a_running_in_table, clock, reset, 1'b1, CNT_W'(running_ff) < count_ff)
   `RRTS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff != '0 && 32'(count_ff) <= MAX_TASKS)
   `RRTS_ASSERT_IMPL(a_switch_cause, clock, reset, rsp_load && sw_ff, cmd_ff == CMD_TICK || cmd_ff == CMD_SLEEP || cmd_ff == CMD_FINISH)

endmodule
